[src/kvmt_pkg.sv]
// Shared types and constants of the key/value match table.
package kvmt_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int KEY_BITS = 64;
	localparam int VALUE_BITS = 64;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam logic [1:0] OP_GET = 2'd0;
	localparam logic [1:0] OP_SET = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [63:0] lookup_key;
		logic [63:0] new_value;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [63:0] read_value;
		logic accepted;
		logic [4:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic commit;
		logic set;
		logic remove;
		logic found;
		logic [KEY_BITS-1:0] key;
		logic [VALUE_BITS-1:0] value;
	} cmd_t;

endpackage

[src/kvmt_cell.sv]
// One entry of the table: key, value, match flag and the links to its neighbors.
module kvmt_cell (
	input logic clk,
	input logic cmp_en,
	input logic [kvmt_pkg::KEY_BITS-1:0] cmp_key,
	input logic live,
	input logic tail,
	input kvmt_pkg::cmd_t cmd,
	input logic [kvmt_pkg::KEY_BITS-1:0] nb_key,
	input logic [kvmt_pkg::VALUE_BITS-1:0] nb_value,
	input logic pfx_in,
	input logic [kvmt_pkg::VALUE_BITS-1:0] rd_in,
	output logic pfx_out,
	output logic [kvmt_pkg::VALUE_BITS-1:0] rd_out,
	output logic [kvmt_pkg::KEY_BITS-1:0] key_out,
	output logic [kvmt_pkg::VALUE_BITS-1:0] value_out
);

	logic [kvmt_pkg::KEY_BITS-1:0] key_q;
	logic [kvmt_pkg::VALUE_BITS-1:0] value_q;
	logic match_q;
	logic shift;
	logic append;
	logic overwrite;

	assign pfx_out = pfx_in | match_q;
	assign rd_out = rd_in | (match_q ? value_q : '0);
	assign key_out = key_q;
	assign value_out = value_q;

	assign shift = cmd.remove && pfx_out;
	assign append = cmd.set && !cmd.found && tail;
	assign overwrite = cmd.set && match_q;

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			match_q <= live && (key_q == cmp_key);
		end
		if (cmd.commit) begin
			if (shift) begin
				key_q <= nb_key;
				value_q <= nb_value;
			end else if (append) begin
				key_q <= cmd.key;
				value_q <= cmd.value;
			end else if (overwrite) begin
				value_q <= cmd.value;
			end
		end
	end

endmodule

[src/key_value_match_table_top.sv]
// Top level of the key/value match table: request stage, cell row and response register.
//
//   channel | direction | payload | handshake
//   req     | in        | req_t   | req_valid / req_stall
//   rsp     | out       | rsp_t   | rsp_valid / rsp_stall
//
// The cells compare their keys on the accepting edge; the update and the response word are
// committed on a later edge, as soon as the response register is free to take the word.
// A new request is taken only once the previous one has been committed.
// If the response register is held by rsp_stall, the pending update waits and req_stall stays high.
// Reset empties the table at once; entry contents are not cleared.
module key_value_match_table_top (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input kvmt_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output kvmt_pkg::rsp_t rsp
);

	localparam int N = kvmt_pkg::TABLE_ENTRIES;
	localparam int KW = kvmt_pkg::KEY_BITS;
	localparam int VW = kvmt_pkg::VALUE_BITS;
	localparam int CW = kvmt_pkg::CNT_W;

	logic busy_q;
	logic [1:0] op_s1;
	logic [KW-1:0] key_s1;
	logic [VW-1:0] value_s1;
	logic [CW-1:0] count_q;
	logic rsp_valid_q;
	kvmt_pkg::rsp_t rsp_q;

	logic accept;
	logic out_free;
	logic commit;
	logic full;
	logic found;
	logic is_get;
	logic is_set;
	logic is_remove;
	logic [KW-1:0] in_key;
	kvmt_pkg::cmd_t cmd;

	logic [N:0] pfx;
	logic [VW-1:0] rd [N+1];
	logic [KW-1:0] key_w [N];
	logic [VW-1:0] value_w [N];

	assign in_key = req.lookup_key[KW-1:0];
	assign req_stall = busy_q;
	assign accept = req_valid && !busy_q;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign commit = busy_q && out_free;

	assign is_get = (op_s1 == kvmt_pkg::OP_GET);
	assign is_set = (op_s1 == kvmt_pkg::OP_SET);
	assign is_remove = (op_s1 == kvmt_pkg::OP_REMOVE);
	assign full = (count_q == CW'(N));
	assign found = pfx[N];

	assign cmd.commit = commit;
	assign cmd.set = is_set;
	assign cmd.remove = is_remove;
	assign cmd.found = found;
	assign cmd.key = key_s1;
	assign cmd.value = value_s1;

	assign pfx[0] = 1'b0;
	assign rd[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [KW-1:0] nb_key;
		logic [VW-1:0] nb_value;

		if (i == N - 1) begin : g_last
			assign nb_key = key_w[i];
			assign nb_value = value_w[i];
		end else begin : g_mid
			assign nb_key = key_w[i+1];
			assign nb_value = value_w[i+1];
		end

		kvmt_cell u_cell (
			.clk      (clk),
			.cmp_en   (accept),
			.cmp_key  (in_key),
			.live     (CW'(i) < count_q),
			.tail     (CW'(i) == count_q),
			.cmd      (cmd),
			.nb_key   (nb_key),
			.nb_value (nb_value),
			.pfx_in   (pfx[i]),
			.rd_in    (rd[i]),
			.pfx_out  (pfx[i+1]),
			.rd_out   (rd[i+1]),
			.key_out  (key_w[i]),
			.value_out(value_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				rsp_valid_q <= 1'b1;
				if (is_set && !found && !full) begin
					count_q <= count_q + CW'(1);
				end else if (is_remove && found) begin
					count_q <= count_q - CW'(1);
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= req.func;
			key_s1 <= in_key;
			value_s1 <= req.new_value;
		end
		if (commit) begin
			rsp_q.hit <= found && (is_get || is_set || is_remove);
			rsp_q.read_value <= (is_get && found) ? 64'(rd[N]) : 64'd0;
			rsp_q.accepted <= !(is_set && !found && full);
			if (is_set && !found && !full) begin
				rsp_q.entry_count <= 5'(count_q + CW'(1));
			end else if (is_remove && found) begin
				rsp_q.entry_count <= 5'(count_q - CW'(1));
			end else begin
				rsp_q.entry_count <= 5'(count_q);
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the key/value match table with a built-in table predictor.
module testbench;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_REQS = 1275;
	localparam int POOL_KEYS = 24;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES = 8;
	localparam logic [63:0] ALL_ONES = {64{1'b1}};
	localparam logic [63:0] KEY_MASK = ALL_ONES >> (64 - kvmt_pkg::KEY_BITS);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	kvmt_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	kvmt_pkg::rsp_t rsp;

	kvmt_pkg::req_t pending_reqs[$];
	kvmt_pkg::rsp_t expected_rsps[$];
	kvmt_pkg::rsp_t oldest_rsp;
	logic [63:0] table_keys[kvmt_pkg::TABLE_ENTRIES];
	logic [63:0] table_values[kvmt_pkg::TABLE_ENTRIES];
	int entries_used = 0;
	int total_reqs = 0;
	int accepted_reqs = 0;
	int error_count = 0;
	int quiet_cycles = 0;

	key_value_match_table_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int idle_pct(bit receiver);
		if (accepted_reqs < total_reqs / 3) begin
			return receiver ? 79 : 26;
		end else if (accepted_reqs < 2 * total_reqs / 3) begin
			return receiver ? 26 : 79;
		end
		return 0;
	endfunction

	function automatic kvmt_pkg::rsp_t apply_table_op(kvmt_pkg::req_t r);
		kvmt_pkg::rsp_t res;
		logic [63:0] key;
		int idx;
		res = '0;
		res.accepted = 1'b1;
		key = r.lookup_key & KEY_MASK;
		idx = -1;
		for (int i = 0; i < entries_used; i++) begin
			if (idx < 0 && table_keys[i] == key) begin
				idx = i;
			end
		end
		case (r.func)
			kvmt_pkg::OP_GET: begin
				if (idx >= 0) begin
					res.hit = 1'b1;
					res.read_value = table_values[idx];
				end
			end
			kvmt_pkg::OP_SET: begin
				if (idx >= 0) begin
					res.hit = 1'b1;
					table_values[idx] = r.new_value;
				end else if (entries_used < kvmt_pkg::TABLE_ENTRIES) begin
					table_keys[entries_used] = key;
					table_values[entries_used] = r.new_value;
					entries_used++;
				end else begin
					res.accepted = 1'b0;
				end
			end
			kvmt_pkg::OP_REMOVE: begin
				if (idx >= 0) begin
					res.hit = 1'b1;
					for (int j = idx; j + 1 < entries_used; j++) begin
						table_keys[j] = table_keys[j + 1];
						table_values[j] = table_values[j + 1];
					end
					entries_used--;
				end
			end
			default: begin
			end
		endcase
		res.entry_count = entries_used[4:0];
		return res;
	endfunction

	task automatic queue_req(logic [1:0] func, logic [63:0] key, logic [63:0] value);
		pending_reqs.push_back({func, key, value});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				expected_rsps.push_back(apply_table_op(req));
				accepted_reqs <= accepted_reqs + 1;
			end
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= $urandom_range(99) < idle_pct(1'b1);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				$error("response word with no request outstanding: %p", rsp);
				error_count++;
			end else begin
				oldest_rsp = expected_rsps.pop_front();
				if (rsp.hit !== oldest_rsp.hit) begin
					$error("hit: expected %0d, actual %0d", oldest_rsp.hit, rsp.hit);
					error_count++;
				end
				if (rsp.read_value !== oldest_rsp.read_value) begin
					$error("read_value: expected %h, actual %h", oldest_rsp.read_value,
						rsp.read_value);
					error_count++;
				end
				if (rsp.accepted !== oldest_rsp.accepted) begin
					$error("accepted: expected %0d, actual %0d", oldest_rsp.accepted,
						rsp.accepted);
					error_count++;
				end
				if (rsp.entry_count !== oldest_rsp.entry_count) begin
					$error("entry_count: expected %0d, actual %0d", oldest_rsp.entry_count,
						rsp.entry_count);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		logic [63:0] key_pool[POOL_KEYS];
		logic [63:0] key;
		logic [63:0] value;
		logic [1:0] func;
		int roll;

		queue_req(kvmt_pkg::OP_GET, '0, ALL_ONES);
		queue_req(kvmt_pkg::OP_REMOVE, ALL_ONES, '0);
		queue_req(OP_UNUSED, 64'h5555_5555_5555_5555, ALL_ONES);
		queue_req(kvmt_pkg::OP_SET, '0, ALL_ONES);
		queue_req(kvmt_pkg::OP_SET, ALL_ONES, '0);
		queue_req(kvmt_pkg::OP_GET, ALL_ONES, ALL_ONES);
		queue_req(kvmt_pkg::OP_GET, '0, '0);
		queue_req(kvmt_pkg::OP_SET, '0, 64'hA5A5_A5A5_5A5A_5A5A);
		for (int i = 0; i < kvmt_pkg::TABLE_ENTRIES - 2; i++) begin
			queue_req(kvmt_pkg::OP_SET, 64'h1 << (4 * i + 1), {$urandom, $urandom});
		end
		// The table is full now, so this new key must be refused.
		queue_req(kvmt_pkg::OP_SET, 64'hDEAD_BEEF_0BAD_F00D, ALL_ONES);
		queue_req(kvmt_pkg::OP_REMOVE, '0, '0);
		queue_req(kvmt_pkg::OP_GET, 64'h1 << 53, '0);

		for (int i = 0; i < POOL_KEYS; i++) begin
			key_pool[i] = {$urandom, $urandom};
		end
		key_pool[0] = '0;
		key_pool[1] = ALL_ONES;

		// Alternate fill-heavy and drain-heavy stretches so the count sweeps empty to full.
		for (int i = 0; i < RANDOM_REQS; i++) begin
			roll = $urandom_range(99);
			if ((i / 64) % 2 == 0) begin
				func = roll < 55 ? kvmt_pkg::OP_SET : roll < 70 ? kvmt_pkg::OP_REMOVE :
					roll < 95 ? kvmt_pkg::OP_GET : OP_UNUSED;
			end else begin
				func = roll < 15 ? kvmt_pkg::OP_SET : roll < 55 ? kvmt_pkg::OP_REMOVE :
					roll < 95 ? kvmt_pkg::OP_GET : OP_UNUSED;
			end
			if ($urandom_range(99) < 85) begin
				key = key_pool[$urandom_range(POOL_KEYS - 1)];
			end else begin
				key = {$urandom, $urandom};
			end
			roll = $urandom_range(9);
			value = roll == 0 ? '0 : roll == 1 ? ALL_ONES : {$urandom, $urandom};
			queue_req(func, key, value);
		end
		total_reqs = pending_reqs.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		while (accepted_reqs < total_reqs || expected_rsps.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

[sim.f]
src/kvmt_pkg.sv
src/kvmt_cell.sv
src/key_value_match_table_top.sv
tb/testbench.sv
